// ===== design/b2da_pkg.sv =====
// Shared constants, types and state encoding for the binary to decimal ASCII block.
// Used by the channel interfaces, the double-dabble unit, the sequencer and the checker.
// No dependencies.
package b2da_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int VALUE_W    = 28;
    localparam int COUNT_W    = 4;
    localparam int CHAR_W     = 7;

    // BCD digits needed for the widest magnitude, or for the widest field, whichever is more
    localparam int BCD_DIGITS = (MAX_DIGITS > 9) ? MAX_DIGITS : 9;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int POS_W      = $clog2(BCD_DIGITS);
    localparam int WIDTH_W    = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W     = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SCAN
    } b2da_state_t;

    // status of the double-dabble unit toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } b2da_dbl_stat_t;

endpackage

// ===== design/b2da_data_if.sv =====
// Input channel: one item carries a signed value and a digit count.
// Depends on b2da_pkg.
interface b2da_data_if;
    logic                                valid;
    logic                                ready;
    logic signed [b2da_pkg::VALUE_W-1:0] value;
    logic [b2da_pkg::COUNT_W-1:0]        digit_count;

    modport source (output valid, output value, output digit_count, input ready);
    modport sink (input valid, input value, input digit_count, output ready);
endinterface

// ===== design/b2da_text_if.sv =====
// Output channel: one item carries one ASCII character with last and overflow flags.
// Depends on b2da_pkg.
interface b2da_text_if;
    logic                        valid;
    logic                        ready;
    logic [b2da_pkg::CHAR_W-1:0] char_code;
    logic                        last;
    logic                        overflow;

    modport source (output valid, output char_code, output last, output overflow, input ready);
    modport sink (input valid, input char_code, input last, input overflow, output ready);
endinterface

// ===== design/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_data_if, b2da_text_if, b2da_dabble and b2da_seq.
//
// Usage:
//   data: one item is a signed 28-bit value and a digit count (0..15). The block
//         takes an item only when idle; ready stays low while an item is worked on.
//   text: one item per ASCII character, most significant first. A negative value
//         gives '-' first. last marks the final character; overflow is set on every
//         character when the magnitude does not fit the field, and the digits then
//         show the magnitude modulo 10^width. Count 0 means eight digits with leading
//         zeros suppressed; counts above eight act as eight.
//   Conversion: the binary to BCD unit runs its shift-add-3 steps in ST_CONV;
//         the first character is registered after it reports done, in ST_SIGN or ST_SCAN.
//         Characters then follow one a cycle while the output is not stalled; each
//         suppressed leading zero is skipped in a scan step that gives no character.
//   Stall: the output register holds a character until taken, and the sequencer
//         waits. The next input item is accepted while the last character waits.
//   Reset: rst_n clears the sequencer and the output valid; no item is in flight.
module binary_to_decimal_ascii
(
    input  logic        clk,
    input  logic        rst_n,
    b2da_data_if.sink   data,
    b2da_text_if.source text
);

    logic [b2da_pkg::VALUE_W-1:0] mag;
    logic [b2da_pkg::BCD_W-1:0]   bcd;
    b2da_pkg::b2da_dbl_stat_t     stat;
    logic                         start;

    // two's complement magnitude; the most negative value maps to 2^27
    assign mag = data.value[b2da_pkg::VALUE_W-1] ? (~data.value + 1'b1) : data.value;

    b2da_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mag   (mag),
        .bcd   (bcd),
        .stat  (stat)
    );

    b2da_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .data  (data),
        .text  (text),
        .bcd   (bcd),
        .stat  (stat),
        .start (start)
    );

endmodule

// ===== design/b2da_dabble.sv =====
// Iterative binary to BCD unit: one shift-and-add-3 step per cycle.
// Depends on b2da_pkg.
module b2da_dabble
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [b2da_pkg::VALUE_W-1:0]  mag,
    output logic [b2da_pkg::BCD_W-1:0]    bcd,
    output b2da_pkg::b2da_dbl_stat_t      stat
);

    logic [b2da_pkg::VALUE_W-1:0] bin_reg;
    logic [b2da_pkg::VALUE_W-1:0] bin_next;
    logic [b2da_pkg::BCD_W-1:0]   bcd_reg;
    logic [b2da_pkg::BCD_W-1:0]   bcd_next;
    logic [b2da_pkg::BCD_W-1:0]   adj;
    logic [b2da_pkg::STEP_W-1:0]  step_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic                         last_step;

    // digits of 5 or more get +3 before the shift
    always_comb
    begin
        for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                        : bcd_reg[i*4 +: 4];
        end
        bcd_next = {adj[b2da_pkg::BCD_W-2:0], bin_reg[b2da_pkg::VALUE_W-1]};
        bin_next = {bin_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
    end

    assign last_step = (step_reg == b2da_pkg::STEP_W'(b2da_pkg::VALUE_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign bcd       = bcd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/b2da_seq.sv =====
// Sequencer: takes input items, runs the BCD unit, then walks the digits and
// drives the output register one character per item. Depends on b2da_pkg and the interfaces.
module b2da_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    b2da_data_if.sink                     data,
    b2da_text_if.source                   text,
    input  logic [b2da_pkg::BCD_W-1:0]    bcd,
    input  b2da_pkg::b2da_dbl_stat_t      stat,
    output logic                          start
);

    b2da_pkg::b2da_state_t          state_reg;
    b2da_pkg::b2da_state_t          state_next;
    logic                           neg_reg;
    logic                           supp_reg;
    logic                           ovf_reg;
    logic [b2da_pkg::WIDTH_W-1:0]   width_reg;
    logic [b2da_pkg::WIDTH_W-1:0]   width_in;
    logic                           supp_in;
    logic [b2da_pkg::POS_W-1:0]     pos_reg;
    logic [3:0]                     digit;
    logic                           ovf_calc;
    logic                           slot_free;
    logic                           skip;
    logic                           emit_sign;
    logic                           emit_dig;
    logic                           accept;
    logic                           out_valid_reg;
    logic [b2da_pkg::CHAR_W-1:0]    char_reg;
    logic                           last_reg;
    logic                           oflag_reg;

    assign accept = data.valid && data.ready;

    always_comb
    begin
        supp_in  = 1'b0;
        width_in = b2da_pkg::WIDTH_W'(b2da_pkg::MAX_DIGITS);
        if (data.digit_count == '0)
        begin
            supp_in = 1'b1;
        end
        else if (data.digit_count <= b2da_pkg::COUNT_W'(b2da_pkg::MAX_DIGITS))
        begin
            width_in = b2da_pkg::WIDTH_W'(data.digit_count);
        end
    end

    // any nonzero digit at or above the field width
    always_comb
    begin
        ovf_calc = 1'b0;
        for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++)
        begin
            if (i >= int'(width_reg) && bcd[i*4 +: 4] != 4'd0)
            begin
                ovf_calc = 1'b1;
            end
        end
    end

    assign digit = bcd[pos_reg*4 +: 4];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = b2da_pkg::ST_CONV;
                end
            end
            b2da_pkg::ST_CONV:
            begin
                if (stat.done)
                begin
                    state_next = neg_reg ? b2da_pkg::ST_SIGN : b2da_pkg::ST_SCAN;
                end
            end
            b2da_pkg::ST_SIGN:
            begin
                if (emit_sign)
                begin
                    state_next = b2da_pkg::ST_SCAN;
                end
            end
            b2da_pkg::ST_SCAN:
            begin
                if (emit_dig && pos_reg == '0)
                begin
                    state_next = b2da_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        slot_free  = !out_valid_reg || text.ready;
        skip       = supp_reg && digit == 4'd0 && pos_reg != '0;
        emit_sign  = 1'b0;
        emit_dig   = 1'b0;
        data.ready = 1'b0;
        case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                data.ready = 1'b1;
            end
            b2da_pkg::ST_SIGN:
            begin
                emit_sign = slot_free;
            end
            b2da_pkg::ST_SCAN:
            begin
                emit_dig = !skip && slot_free;
            end
            default:
            begin
                emit_sign = 1'b0;
            end
        endcase
    end

    assign start = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b2da_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_sign || emit_dig)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg   <= data.value[b2da_pkg::VALUE_W-1];
            supp_reg  <= supp_in;
            width_reg <= width_in;
        end
        if (state_reg == b2da_pkg::ST_CONV && stat.done)
        begin
            ovf_reg <= ovf_calc;
            pos_reg <= b2da_pkg::POS_W'(width_reg - 1'b1);
        end
        else if (state_reg == b2da_pkg::ST_SCAN && (skip || emit_dig) && pos_reg != '0)
        begin
            pos_reg <= pos_reg - 1'b1;
        end
        if (emit_dig)
        begin
            supp_reg <= 1'b0;
        end
        if (emit_sign)
        begin
            char_reg  <= b2da_pkg::CHAR_MINUS;
            last_reg  <= 1'b0;
            oflag_reg <= ovf_reg;
        end
        else if (emit_dig)
        begin
            char_reg  <= b2da_pkg::CHAR_ZERO + {3'b000, digit};
            last_reg  <= (pos_reg == '0);
            oflag_reg <= ovf_reg;
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.char_code = char_reg;
    assign text.last      = last_reg;
    assign text.overflow  = oflag_reg;

endmodule

// ===== design/b2da_checker.sv =====
// Port-level checks for binary_to_decimal_ascii, attached by bind.
// Depends on b2da_pkg.
module b2da_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        data_valid,
    input logic                        data_ready,
    input logic                        text_valid,
    input logic                        text_ready,
    input logic [b2da_pkg::CHAR_W-1:0] char_code,
    input logic                        last,
    input logic                        overflow
);

    // a stalled character holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(char_code)
            && $stable(last) && $stable(overflow))
        else $error("stalled text item changed");

    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> char_code == b2da_pkg::CHAR_MINUS
            || (char_code >= b2da_pkg::CHAR_ZERO && char_code <= b2da_pkg::CHAR_NINE))
        else $error("character out of set");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && char_code == b2da_pkg::CHAR_MINUS |-> !last)
        else $error("sign marked last");

    // busy after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && data_ready |=> !data_ready)
        else $error("ready right after accept");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .data_valid (data.valid),
    .data_ready (data.ready),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .char_code  (text.char_code),
    .last       (text.last),
    .overflow   (text.overflow)
);
